>>> rtl/tad_pkg.sv
// ----------------------------------------------------------------------------
// tad_pkg
// Shared types and codes for the teletext attribute decoder: cell kinds,
// graphics modes, the row attribute record and the decoded cell record.
// ----------------------------------------------------------------------------
package tad_pkg;

  // Default geometry and glyph offset.
  localparam int ROW_CELLS_DEF    = 40;
  localparam int PAGE_ROWS_DEF    = 25;
  localparam int GLYPH_OFFSET_DEF = 128;

  // Cell kinds.
  localparam logic [1:0] KIND_BLANK  = 2'd0;
  localparam logic [1:0] KIND_GLYPH  = 2'd1;
  localparam logic [1:0] KIND_MOSAIC = 2'd2;

  // Graphics modes.
  localparam logic [1:0] MODE_ALPHA  = 2'd0;
  localparam logic [1:0] MODE_CONTIG = 2'd1;
  localparam logic [1:0] MODE_SEPAR  = 2'd2;

  // Colors.
  localparam logic [2:0] COLOR_BLACK = 3'd0;
  localparam logic [2:0] COLOR_WHITE = 3'd7;

  // Control code boundaries.
  localparam logic [7:0] CODE_ALPHA_BASE  = 8'h80;
  localparam logic [7:0] CODE_MOSAIC_BASE = 8'h90;
  localparam logic [7:0] CODE_HEIGHT_LO   = 8'h8C;
  localparam logic [7:0] CODE_HEIGHT_HI   = 8'h8D;
  localparam logic [7:0] CODE_CONTIG      = 8'h99;
  localparam logic [7:0] CODE_SEPAR       = 8'h9A;
  localparam logic [7:0] CODE_BLACK_BACK  = 8'h9C;
  localparam logic [7:0] CODE_NEW_BACK    = 8'h9D;
  localparam logic [7:0] CODE_HOLD_OFF    = 8'h9E;
  localparam logic [7:0] CODE_HOLD_ON     = 8'h9F;
  localparam logic [7:0] CODE_PRINT_BASE  = 8'hA0;
  localparam logic [7:0] CODE_CAPS_LO     = 8'hC0;
  localparam logic [7:0] CODE_CAPS_HI     = 8'hDF;

  // Row attributes kept from cell to cell.
  typedef struct packed {
    logic [2:0] fore;
    logic [2:0] back;
    logic [1:0] mode;
    logic       height;
    logic       hold;
  } tad_attr_t;

  localparam tad_attr_t ATTR_ROW_RESET = '{
    fore:   COLOR_WHITE,
    back:   COLOR_BLACK,
    mode:   MODE_ALPHA,
    height: 1'b0,
    hold:   1'b0
  };

  // One decoded cell, without its position.
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] glyph;
    logic [5:0] sixels;
    logic       separated;
    logic [2:0] fore;
    logic [2:0] back;
    logic       height;
    logic       hold;
  } tad_cell_t;

endpackage

>>> rtl/tad_in_if.sv
// ----------------------------------------------------------------------------
// tad_in_if
// Input channel: one teletext page byte per transfer.
// ----------------------------------------------------------------------------
interface tad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

>>> rtl/tad_out_if.sv
// ----------------------------------------------------------------------------
// tad_out_if
// Result channel: one decoded cell per transfer.
// ----------------------------------------------------------------------------
interface tad_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] cell_kind;
  logic [6:0] glyph_code;
  logic [5:0] sixel_mask;
  logic       separated;
  logic [2:0] fore_colour;
  logic [2:0] back_colour;
  logic       double_height;
  logic       hold_flag;
  logic [5:0] column;
  logic [4:0] row_number;

  modport source (
    output valid, output cell_kind, output glyph_code, output sixel_mask,
    output separated, output fore_colour, output back_colour,
    output double_height, output hold_flag, output column, output row_number,
    input ready
  );
  modport sink (
    input valid, input cell_kind, input glyph_code, input sixel_mask,
    input separated, input fore_colour, input back_colour,
    input double_height, input hold_flag, input column, input row_number,
    output ready
  );
endinterface

>>> rtl/tad_cell_dec.sv
// ----------------------------------------------------------------------------
// tad_cell_dec
// Decodes one page byte against the current row attributes. Control codes
// update the attributes, and the updated set already applies to the
// control code's own (blank) cell.
// ----------------------------------------------------------------------------
module tad_cell_dec
  import tad_pkg::*;
#(
  parameter int GLYPH_OFFSET = GLYPH_OFFSET_DEF
) (
  input  logic [7:0] code_byte,
  input  tad_attr_t  attr_i,
  output tad_attr_t  attr_o,
  output tad_cell_t  cell_o
);

  // Only the low seven bits of the offset matter for a modulo-128 result.
  localparam logic [6:0] GlyphOffLow = 7'(GLYPH_OFFSET % 128);

  logic is_control;
  logic is_caps;

  assign is_control = (code_byte < CODE_PRINT_BASE);
  assign is_caps    = (code_byte >= CODE_CAPS_LO) && (code_byte <= CODE_CAPS_HI);

  // Attribute update for control codes; anything else leaves them alone.
  always_comb begin
    attr_o = attr_i;
    unique case (code_byte) inside
      [8'h81:8'h87]: begin
        attr_o.mode = MODE_ALPHA;
        attr_o.fore = 3'(code_byte - CODE_ALPHA_BASE);
      end
      [8'h91:8'h97]: begin
        attr_o.mode = MODE_CONTIG;
        attr_o.fore = 3'(code_byte - CODE_MOSAIC_BASE);
      end
      CODE_HEIGHT_LO:  attr_o.height = 1'b0;
      CODE_HEIGHT_HI:  attr_o.height = 1'b1;
      CODE_CONTIG:     attr_o.mode   = MODE_CONTIG;
      CODE_SEPAR:      attr_o.mode   = MODE_SEPAR;
      CODE_BLACK_BACK: attr_o.back   = COLOR_BLACK;
      CODE_NEW_BACK:   attr_o.back   = attr_i.fore;
      CODE_HOLD_OFF:   attr_o.hold   = 1'b0;
      CODE_HOLD_ON:    attr_o.hold   = 1'b1;
      default: ;
    endcase
  end

  // Cell contents: blank for controls, glyph in alpha mode or for the
  // capital range, mosaic sixels otherwise.
  always_comb begin
    cell_o           = '0;
    cell_o.separated = (attr_o.mode == MODE_SEPAR);
    cell_o.fore      = attr_o.fore;
    cell_o.back      = attr_o.back;
    cell_o.height    = attr_o.height;
    cell_o.hold      = attr_o.hold;
    if (is_control) begin
      cell_o.kind = KIND_BLANK;
    end else if (is_caps || (attr_i.mode == MODE_ALPHA)) begin
      cell_o.kind  = KIND_GLYPH;
      cell_o.glyph = code_byte[6:0] - GlyphOffLow;
    end else begin
      cell_o.kind   = KIND_MOSAIC;
      cell_o.sixels = {code_byte[6], code_byte[4:0]};
    end
  end

endmodule

>>> rtl/teletext_attribute_decoder_core.sv
// ----------------------------------------------------------------------------
// teletext_attribute_decoder_core
// Serial teletext attribute decoder: page bytes in row-major order come in,
// one decoded cell with colors, flags and position goes out per byte.
//
//   Channel | Direction | Payload
//   in_ch   | sink      | code_byte
//   out_ch  | source    | cell_kind, glyph_code, sixel_mask, separated,
//           |           | fore_colour, back_colour, double_height,
//           |           | hold_flag, column, row_number
//
// One byte per cycle sustained while out_ch is ready; each byte passes the
// input register, then the result register, which offers its cell.
// The attribute and position registers update as a cell enters the result
// register, so consecutive bytes chain through them without bubbles.
// Synchronous active-low reset returns to row 0, column 0, white on black.
// A stalled result holds the pipeline; the input register still takes a
// byte while the result register is full and the input stage is empty.
// ----------------------------------------------------------------------------
module teletext_attribute_decoder_core
  import tad_pkg::*;
#(
  parameter int ROW_CELLS    = ROW_CELLS_DEF,
  parameter int PAGE_ROWS    = PAGE_ROWS_DEF,
  parameter int GLYPH_OFFSET = GLYPH_OFFSET_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tad_in_if.sink    in_ch,
  tad_out_if.source out_ch
);

  localparam logic [5:0] LastCol = 6'(ROW_CELLS - 1);
  localparam logic [4:0] LastRow = 5'(PAGE_ROWS - 1);

  // Input stage.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;

  // Result stage.
  logic       out_valid_r, out_valid_nxt;
  tad_cell_t  out_cell_r;
  logic [5:0] out_col_r;
  logic [4:0] out_row_r;

  // Row state.
  tad_attr_t  attr_r, attr_nxt;
  logic [5:0] col_r, col_nxt;
  logic [4:0] row_r, row_nxt;

  logic       in_xfer;
  logic       advance;
  tad_attr_t  attr_upd;
  tad_cell_t  dec_cell;

  // Handshake: the input stage moves on when the result register is free.
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  tad_cell_dec #(
    .GLYPH_OFFSET(GLYPH_OFFSET)
  ) u_dec (
    .code_byte(s1_byte_r),
    .attr_i   (attr_r),
    .attr_o   (attr_upd),
    .cell_o   (dec_cell)
  );

  // Next control and row state.
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    attr_nxt      = attr_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      if (col_r == LastCol) begin
        col_nxt  = '0;
        attr_nxt = ATTR_ROW_RESET;
        row_nxt  = (row_r == LastRow) ? '0 : row_r + 5'd1;
      end else begin
        col_nxt  = col_r + 6'd1;
        attr_nxt = attr_upd;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      attr_r      <= ATTR_ROW_RESET;
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      attr_r      <= attr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_ch.code_byte;
    end
    if (advance) begin
      out_cell_r <= dec_cell;
      out_col_r  <= col_r;
      out_row_r  <= row_r;
    end
  end

  // Result channel.
  assign out_ch.valid         = out_valid_r;
  assign out_ch.cell_kind     = out_cell_r.kind;
  assign out_ch.glyph_code    = out_cell_r.glyph;
  assign out_ch.sixel_mask    = out_cell_r.sixels;
  assign out_ch.separated     = out_cell_r.separated;
  assign out_ch.fore_colour   = out_cell_r.fore;
  assign out_ch.back_colour   = out_cell_r.back;
  assign out_ch.double_height = out_cell_r.height;
  assign out_ch.hold_flag     = out_cell_r.hold;
  assign out_ch.column        = out_col_r;
  assign out_ch.row_number    = out_row_r;

endmodule
